>>> rtl/ssfo_pkg.sv
package ssfo_pkg;

  // default sizing of the search
  localparam int PATTERN_MAX_DEF = 8;
  localparam int TEXT_MAX_DEF    = 32768;

  // fixed field widths
  localparam int UNIT_W    = 16;
  localparam int REG_UNITS = 8;
  localparam int SEL_W     = $clog2(REG_UNITS);
  localparam int LEN_W     = 4;
  localparam int MPOS_W    = 15;
  localparam int START_W   = 16;
  localparam int CFG_W     = 64;

  // pattern units as held in the configuration registers, unit 0 lowest
  typedef logic [REG_UNITS-1:0][UNIT_W-1:0] unit_arr_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_START    = 2'd3
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              is_end;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [MPOS_W-1:0] match_position;
    status_t           status;
  } result_t;

  typedef struct packed {
    cfg_reg_t         index;
    logic [CFG_W-1:0] value;
  } cfg_write_t;

endpackage

>>> rtl/ssfo_chan_if.sv
interface ssfo_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ssfo_cell.sv
module ssfo_cell import ssfo_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [UNIT_W-1:0] d_in,
  input  unit_arr_t         pattern,
  input  logic [LEN_W-1:0]  eff_len,
  output logic [UNIT_W-1:0] q,
  output logic              hit_ok
);

  localparam logic [LEN_W:0] K = (LEN_W+1)'(IDX);

  logic [LEN_W:0] len_x;
  logic [LEN_W:0] sel_full;
  logic           in_use;

  // this cell sees pattern unit len-1-k once the new unit has shifted in
  assign len_x    = {1'b0, eff_len};
  assign in_use   = len_x > K;
  assign sel_full = len_x - K - (LEN_W+1)'(1);
  assign hit_ok   = !in_use || (d_in == pattern[sel_full[SEL_W-1:0]]);

  // window stage, moves one place on every code unit taken within the length limit
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d_in;
    end
  end

endmodule

>>> rtl/ssfo_out_buf.sv
module ssfo_out_buf import ssfo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  ssfo_chan_if.source res
);

  logic [1:0] count;
  result_t    head;
  result_t    spare;
  logic       pop;

  assign pop       = res.valid && res.ready;
  assign res.valid = count != 2'd0;
  assign res.data  = head;
  assign full      = count == 2'd2;

  // two-entry result queue, head drives the port
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
    if (pop) begin
      head <= (count == 2'd2) ? spare : push_data;
    end else if (count == 2'd0 && push) begin
      head <= push_data;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      spare <= push_data;
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result queue count out of range");
  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
      (count == 2'd2 && !pop) |-> !push)
    else $error("result pushed into full queue");
  a_full_holds : assert property (@(posedge clk) disable iff (rst)
      (count == 2'd2 && !pop) |=> full)
    else $error("full queue lost an entry");

endmodule

>>> rtl/substring_search_from_offset.sv
// Streaming substring search. Code units of a text arrive on text_in, one per
// transaction, and a transaction with is_end set closes the text and yields one
// result on result_out: the first position at or after search_start where the
// configured pattern (up to eight units) lies wholly in the text, or an
// out-of-range or text-too-long status. The block takes one code unit every
// cycle while the result queue is not full: a row of PATTERN_MAX window cells
// shifts on each unit accepted within the length limit, and every cell compares
// its new unit against its pattern unit in that same cycle, so the match
// decision is complete when the unit is accepted. The result is registered into
// a two-entry result queue, which lets input run on while results wait, and
// text_in.ready falls only when two results are queued. Configuration writes
// are accepted every cycle and belong between texts.
module substring_search_from_offset import ssfo_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssfo_chan_if.sink   text_in,
  ssfo_chan_if.source result_out,
  ssfo_chan_if.sink   cfg
);

  localparam int POS_W = $clog2(TEXT_MAX + 1);
  localparam int CMP_W = (POS_W > START_W) ? POS_W : START_W;
  localparam int LEN_CAP = (PATTERN_MAX < REG_UNITS) ? PATTERN_MAX : REG_UNITS;

  // configuration registers
  unit_arr_t          pattern;
  logic [LEN_W-1:0]   pattern_length;
  logic [START_W-1:0] search_start;

  // stream state
  logic [POS_W-1:0]  text_position;
  logic              hit_seen;
  logic [MPOS_W-1:0] hit_position;
  logic              length_overflow;

  logic              in_acc;
  logic              buf_full;
  logic              unit_take;
  logic              end_take;
  logic              at_limit;
  logic [LEN_W-1:0]  eff_len;
  logic [POS_W-1:0]  pos_inc;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  start_pos;
  logic              start_neg;
  logic [CMP_W-1:0]  match_start;
  logic              start_ok;
  logic              take_hit;
  logic              start_bad;
  result_t           res_next;

  logic [UNIT_W-1:0]      win_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_ok;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= '0;
      search_start   <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_PAT_LOW:  pattern[REG_UNITS/2-1:0] <= cfg.data.value;
        REG_PAT_HIGH: pattern[REG_UNITS-1:REG_UNITS/2] <= cfg.data.value;
        REG_PAT_LEN:  pattern_length <= cfg.data.value[LEN_W-1:0];
        REG_START:    search_start <= cfg.data.value[START_W-1:0];
        default:      pattern_length <= pattern_length;
      endcase
    end
  end

  // saturated pattern length
  assign eff_len = (pattern_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : pattern_length;

  // input handshake
  assign text_in.ready = !buf_full;
  assign in_acc        = text_in.valid && text_in.ready;
  assign at_limit      = text_position >= POS_W'(TEXT_MAX);
  assign end_take      = in_acc && text_in.data.is_end;
  assign unit_take     = in_acc && !text_in.data.is_end && !length_overflow && !at_limit;

  // window cells
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic [UNIT_W-1:0] d_in;
    if (g == 0) begin : g_head
      assign d_in = text_in.data.code_unit;
    end else begin : g_link
      assign d_in = win_q[g-1];
    end
    ssfo_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .shift_en (unit_take),
      .d_in     (d_in),
      .pattern  (pattern),
      .eff_len  (eff_len),
      .q        (win_q[g]),
      .hit_ok   (cell_ok[g])
    );
  end

  // candidate match start and offset checks
  assign pos_inc     = text_position + POS_W'(1);
  assign pos_ext     = CMP_W'(pos_inc);
  assign len_ext     = CMP_W'(eff_len);
  assign start_neg   = search_start[START_W-1];
  assign start_pos   = CMP_W'(search_start[START_W-2:0]);
  assign match_start = pos_ext - len_ext;
  assign start_ok    = start_neg || (match_start >= start_pos);
  assign take_hit    = unit_take && (eff_len != '0) && !hit_seen && (pos_ext >= len_ext)
                       && start_ok && (&cell_ok);
  assign start_bad   = start_neg || (start_pos >= CMP_W'(text_position));

  // result of the text at the terminator
  always_comb begin
    res_next.found          = 1'b0;
    res_next.match_position = '0;
    res_next.status         = ST_OK;
    if (length_overflow) begin
      res_next.status = ST_LONG;
    end else if (start_bad) begin
      res_next.status = ST_RANGE;
    end else if (eff_len == '0) begin
      res_next.found          = 1'b1;
      res_next.match_position = search_start[MPOS_W-1:0];
    end else if (hit_seen) begin
      res_next.found          = 1'b1;
      res_next.match_position = hit_position;
    end
  end

  // stream state update
  always_ff @(posedge clk) begin
    if (rst) begin
      text_position   <= '0;
      hit_seen        <= 1'b0;
      length_overflow <= 1'b0;
    end else if (end_take) begin
      text_position   <= '0;
      hit_seen        <= 1'b0;
      length_overflow <= 1'b0;
    end else if (in_acc) begin
      if (length_overflow || at_limit) begin
        length_overflow <= 1'b1;
      end else begin
        text_position <= pos_inc;
        if (take_hit) begin
          hit_seen <= 1'b1;
        end
      end
    end
    if (take_hit) begin
      hit_position <= match_start[MPOS_W-1:0];
    end
  end

  ssfo_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (end_take),
    .push_data (res_next),
    .full      (buf_full),
    .res       (result_out)
  );

  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
      text_position <= POS_W'(TEXT_MAX))
    else $error("text position beyond maximum length");
  a_end_clears : assert property (@(posedge clk) disable iff (rst)
      end_take |=> (text_position == '0 && !hit_seen && !length_overflow))
    else $error("stream state not cleared after terminator");
  a_unit_counts : assert property (@(posedge clk) disable iff (rst)
      unit_take |=> text_position == POS_W'($past(text_position) + 1'b1))
    else $error("position did not advance on accepted unit");
  a_hit_once : assert property (@(posedge clk) disable iff (rst)
      (hit_seen && !end_take) |=> hit_seen && $stable(hit_position))
    else $error("first hit changed within a text");

endmodule
